>>> design/nvme_prp_descriptor_builder_top_assert.svh
// ----------------------------------------------------------------------------
// PRP descriptor builder assertion macros
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NVME_PRP_DESCRIPTOR_BUILDER_TOP_ASSERT_SVH
`define NVME_PRP_DESCRIPTOR_BUILDER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define NPDB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define NPDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NPDB_ASSERT_SAME(lbl, ante, cons, msg)
`define NPDB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/npdb_pkg.sv
// ----------------------------------------------------------------------------
// npdb_pkg
// Shared types and codes of the PRP descriptor builder.
// ----------------------------------------------------------------------------
package npdb_pkg;

  localparam int PAGE_BYTES_DEF    = 4096;
  localparam int LIST_CAPACITY_DEF = 512;

  localparam int APB_AW = 4;
  localparam int APB_DW = 64;

  // register index, taken from paddr[3]
  localparam logic REG_LIST_BASE = 1'b0;

  localparam logic [1:0] KIND_BUILD   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] dma_address;
    logic [31:0] xfer_len;
    logic [8:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] prp_first;
    logic [63:0] prp_second;
    logic [1:0]  status;
    logic [9:0]  list_entries;
    logic [63:0] entry_value;
  } res_t;

  // list state update requests from the datapath
  typedef struct packed {
    logic busy_clr;
    logic list_load;
    logic count_clr;
  } upd_t;

endpackage

>>> design/nvme_prp_descriptor_builder_top.sv
// ----------------------------------------------------------------------------
// nvme_prp_descriptor_builder_top
// PRP1/PRP2 builder with PRP list bookkeeping for page-based DMA transfers.
// ----------------------------------------------------------------------------
// Input channel (in_*): build, release or list-entry read items, valid/ready.
// Result channel (out_*): one result item per input item, valid/ready, in
// input order.
// APB port: one 64-bit register, the PRP list base, at byte address 0.
// An item taken is held in the input register, then registered in the result
// register that drives out_*. Throughput: one item per cycle while out_ready
// is high, set by the single combinational pass between the two registers.
// A build needing a list marks the list busy until a release item; reads
// return list entries from the last recorded list.
// Receiver stall: the result register holds; the input register then holds
// the following item and in_ready drops until out_ready returns.
// Reset (synchronous, rst_n low): list free, count and first page zero,
// list base zero, both channels empty.
// ----------------------------------------------------------------------------
`include "nvme_prp_descriptor_builder_top_assert.svh"

module nvme_prp_descriptor_builder_top #(
  parameter int PAGE_BYTES    = npdb_pkg::PAGE_BYTES_DEF,
  parameter int LIST_CAPACITY = npdb_pkg::LIST_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [63:0]                 in_dma_address,
  input  logic [31:0]                 in_xfer_len,
  input  logic [8:0]                  in_entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [63:0]                 out_prp_first,
  output logic [63:0]                 out_prp_second,
  output logic [1:0]                  out_status,
  output logic [9:0]                  out_list_entries,
  output logic [63:0]                 out_entry_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npdb_pkg::APB_AW-1:0] paddr,
  input  logic [npdb_pkg::APB_DW-1:0] pwdata,
  output logic [npdb_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import npdb_pkg::*;

  localparam int CW = $clog2(LIST_CAPACITY + 1);

  logic          in_valid_r,  in_valid_nxt;
  in_item_t      item_r;
  logic          out_valid_r, out_valid_nxt;
  res_t          res_r;
  logic          list_busy_r, list_busy_nxt;
  logic [63:0]   list_first_page_r, list_first_page_nxt;
  logic [CW-1:0] list_count_r, list_count_nxt;

  logic [63:0]   list_base;
  res_t          res_c;
  upd_t          upd_c;
  logic [63:0]   load_page;
  logic [CW-1:0] load_count;
  logic          advance;
  logic          take_in;

  npdb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .list_base (list_base)
  );

  npdb_calc #(
    .PAGE_BYTES    (PAGE_BYTES),
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_calc (
    .item            (item_r),
    .list_busy       (list_busy_r),
    .list_first_page (list_first_page_r),
    .list_count      (list_count_r),
    .list_base       (list_base),
    .res             (res_c),
    .upd             (upd_c),
    .load_page       (load_page),
    .load_count      (load_count)
  );

  // item moves from input register to result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign take_in  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt        = take_in || (in_valid_r && !advance);
    out_valid_nxt       = advance || (out_valid_r && !out_ready);
    list_busy_nxt       = list_busy_r;
    list_first_page_nxt = list_first_page_r;
    list_count_nxt      = list_count_r;
    if (advance) begin
      if (upd_c.busy_clr) begin
        list_busy_nxt = 1'b0;
      end
      if (upd_c.count_clr) begin
        list_count_nxt = '0;
      end
      if (upd_c.list_load) begin
        list_busy_nxt       = 1'b1;
        list_first_page_nxt = load_page;
        list_count_nxt      = load_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      list_busy_r       <= 1'b0;
      list_first_page_r <= '0;
      list_count_r      <= '0;
    end else begin
      in_valid_r        <= in_valid_nxt;
      out_valid_r       <= out_valid_nxt;
      list_busy_r       <= list_busy_nxt;
      list_first_page_r <= list_first_page_nxt;
      list_count_r      <= list_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      item_r.kind        <= in_kind;
      item_r.dma_address <= in_dma_address;
      item_r.xfer_len    <= in_xfer_len;
      item_r.entry_index <= in_entry_index;
    end
    if (advance) begin
      res_r <= res_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prp_first    = res_r.prp_first;
  assign out_prp_second   = res_r.prp_second;
  assign out_status       = res_r.status;
  assign out_list_entries = res_r.list_entries;
  assign out_entry_value  = res_r.entry_value;

  // a busy list always describes at least two pages
  `NPDB_ASSERT_SAME(a_busy_has_entries, list_busy_r, list_count_r != '0,
    "list busy with empty count")
  // a successful list build leaves the list busy
  `NPDB_ASSERT_NEXT(a_load_sets_busy, advance && upd_c.list_load,
    list_busy_r && (list_count_r != '0), "list build did not mark busy")
  // a held item stays put while the result side is stalled
  `NPDB_ASSERT_NEXT(a_hold_item, in_valid_r && !advance,
    in_valid_r && $stable(item_r), "held item lost or changed")

endmodule

>>> design/npdb_cfg.sv
// ----------------------------------------------------------------------------
// npdb_cfg
// APB register file holding the PRP list base address.
// ----------------------------------------------------------------------------
module npdb_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npdb_pkg::APB_AW-1:0] paddr,
  input  logic [npdb_pkg::APB_DW-1:0] pwdata,
  output logic [npdb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [63:0]                list_base
);
  import npdb_pkg::*;

  logic [63:0] list_base_r;
  logic        wr_en;
  logic        reg_hit;

  // paddr[3] selects the register; the low three bits are ignored
  assign reg_hit = (paddr[3] == REG_LIST_BASE);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_base_r <= '0;
    end else if (wr_en) begin
      list_base_r <= pwdata;
    end
  end

  assign prdata    = reg_hit ? list_base_r : '0;
  assign list_base = list_base_r;

endmodule

>>> design/npdb_calc.sv
// ----------------------------------------------------------------------------
// npdb_calc
// Single-pass PRP page arithmetic: result fields and list state updates.
// ----------------------------------------------------------------------------
module npdb_calc #(
  parameter int PAGE_BYTES    = npdb_pkg::PAGE_BYTES_DEF,
  parameter int LIST_CAPACITY = npdb_pkg::LIST_CAPACITY_DEF,
  localparam int PW = $clog2(PAGE_BYTES),
  localparam int CW = $clog2(LIST_CAPACITY + 1)
) (
  input  npdb_pkg::in_item_t item,
  input  logic               list_busy,
  input  logic [63:0]        list_first_page,
  input  logic [CW-1:0]      list_count,
  input  logic [63:0]        list_base,
  output npdb_pkg::res_t     res,
  output npdb_pkg::upd_t     upd,
  output logic [63:0]        load_page,
  output logic [CW-1:0]      load_count
);
  import npdb_pkg::*;

  logic [PW-1:0]    offset;
  logic [PW:0]      avail;
  logic [31:0]      rem;
  logic             fits_one;
  logic             fits_two;
  logic [32:0]      ent_sum;
  logic [32:0]      entries;
  logic             too_large;
  logic [63-PW:0]   page_hi;
  logic [63:0]      page_after;
  logic             idx_hit;
  logic [63:0]      rd_value;

  always_comb begin
    offset    = item.dma_address[PW-1:0];
    avail     = (PW+1)'(PAGE_BYTES) - {1'b0, offset};
    fits_one  = item.xfer_len <= 32'(avail);
    rem       = item.xfer_len - 32'(avail);
    fits_two  = rem <= 32'(PAGE_BYTES);
    // ceil(rem / page)
    ent_sum   = {1'b0, rem} + 33'(PAGE_BYTES - 1);
    entries   = ent_sum >> PW;
    too_large = entries > 33'(LIST_CAPACITY);
    page_hi   = item.dma_address[63:PW] + (64-PW)'(1);
    page_after = {page_hi, {PW{1'b0}}};
    idx_hit   = 32'(item.entry_index) < 32'(list_count);
    rd_value  = list_first_page + (64'(item.entry_index) << PW);
  end

  always_comb begin
    res        = '0;
    upd        = '0;
    load_page  = page_after;
    load_count = entries[CW-1:0];
    case (item.kind)
      KIND_BUILD: begin
        res.prp_first = item.dma_address;
        if (fits_one) begin
          res.status = ST_OK;
        end else if (fits_two) begin
          res.prp_second = page_after;
        end else if (list_busy) begin
          res.status = ST_BUSY;
        end else if (too_large) begin
          res.status    = ST_TOO_LARGE;
          upd.busy_clr  = 1'b1;
          upd.count_clr = 1'b1;
        end else begin
          res.prp_second   = list_base;
          res.list_entries = entries[9:0];
          upd.list_load    = 1'b1;
        end
      end
      KIND_RELEASE: begin
        upd.busy_clr = 1'b1;
      end
      KIND_READ: begin
        res.entry_value = idx_hit ? rd_value : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> dv/nvme_prp_checker.sv
// ----------------------------------------------------------------------------
// nvme_prp_checker
// Watches the item, result and register ports of the PRP descriptor builder,
// predicts every result from its own copy of the list state and list base,
// and compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module nvme_prp_checker #(
  parameter int PAGE_BYTES    = npdb_pkg::PAGE_BYTES_DEF,
  parameter int LIST_CAPACITY = npdb_pkg::LIST_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [63:0]                 in_dma_address,
  input  logic [31:0]                 in_xfer_len,
  input  logic [8:0]                  in_entry_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [63:0]                 out_prp_first,
  input  logic [63:0]                 out_prp_second,
  input  logic [1:0]                  out_status,
  input  logic [9:0]                  out_list_entries,
  input  logic [63:0]                 out_entry_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npdb_pkg::APB_AW-1:0] paddr,
  input  logic [npdb_pkg::APB_DW-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import npdb_pkg::*;

  localparam logic [63:0] PAGE = 64'(PAGE_BYTES);

  // predictor state
  logic [63:0] list_base;
  logic        list_busy;
  logic [63:0] list_first_page;
  int unsigned list_count;

  res_t     prp_expected_q[$];
  res_t     exp_res;
  res_t     got_res;
  in_item_t taken;

  function automatic res_t build_prp(in_item_t it);
    logic [63:0] offset;
    logic [63:0] avail;
    logic [63:0] page_origin;
    logic [63:0] page_after;
    logic [63:0] bytes;
    logic [63:0] rem;
    logic [63:0] entries;
    res_t        r;
    r = '0;
    case (it.kind)
      KIND_BUILD: begin
        offset      = it.dma_address & (PAGE - 64'd1);
        avail       = PAGE - offset;
        page_origin = it.dma_address & ~(PAGE - 64'd1);
        page_after  = page_origin + PAGE;
        bytes       = 64'(it.xfer_len);
        rem         = bytes - avail;
        r.prp_first = it.dma_address;
        if (bytes <= avail) begin
          r.prp_second = '0;
        end else if (rem <= PAGE) begin
          r.prp_second = page_after;
        end else if (list_busy) begin
          r.status = ST_BUSY;
        end else begin
          entries = (rem + PAGE - 64'd1) / PAGE;
          if (entries > 64'(LIST_CAPACITY)) begin
            list_busy  = 1'b0;
            list_count = 0;
            r.status   = ST_TOO_LARGE;
          end else begin
            list_busy       = 1'b1;
            list_first_page = page_after;
            list_count      = int'(entries);
            r.prp_second    = list_base;
            r.list_entries  = entries[9:0];
          end
        end
      end
      KIND_RELEASE: begin
        list_busy = 1'b0;
      end
      KIND_READ: begin
        // a released list stays readable until the next build that needs a list
        if (32'(it.entry_index) < list_count)
          r.entry_value = list_first_page + 64'(it.entry_index) * PAGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(res_t e, res_t a);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch: exp p1=%h p2=%h st=%0d ents=%0d val=%h", $realtime,
               e.prp_first, e.prp_second, e.status, e.list_entries, e.entry_value,
               "\n           got p1=%h p2=%h st=%0d ents=%0d val=%h",
               a.prp_first, a.prp_second, a.status, a.list_entries, a.entry_value);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      list_base       = '0;
      list_busy       = 1'b0;
      list_first_page = '0;
      list_count      = 0;
      prp_expected_q.delete();
      fail_count      = 0;
    end else begin
      // compare before pushing: a result never belongs to an item taken this edge
      if (out_valid && out_ready) begin
        got_res = '{prp_first: out_prp_first, prp_second: out_prp_second,
                    status: out_status, list_entries: out_list_entries,
                    entry_value: out_entry_value};
        if (prp_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t result with nothing outstanding: p1=%h p2=%h st=%0d",
                     $realtime, out_prp_first, out_prp_second, out_status);
        end else begin
          exp_res = prp_expected_q.pop_front();
          if (got_res.prp_first !== exp_res.prp_first ||
              got_res.prp_second !== exp_res.prp_second ||
              got_res.status !== exp_res.status ||
              got_res.list_entries !== exp_res.list_entries ||
              got_res.entry_value !== exp_res.entry_value)
            note_mismatch(exp_res, got_res);
        end
      end
      if (in_valid && in_ready) begin
        taken = '{kind: in_kind, dma_address: in_dma_address,
                  xfer_len: in_xfer_len, entry_index: in_entry_index};
        prp_expected_q.push_back(build_prp(taken));
      end
      if (psel && penable && pwrite && pready && paddr[3] == REG_LIST_BASE)
        list_base = pwdata;
    end
    pending = prp_expected_q.size();
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives build, release and list-read items into the PRP descriptor builder
// under several list base settings, with random gaps on both channels and a
// long result stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import npdb_pkg::*;

  localparam logic [1:0]        KIND_UNUSED    = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_LIST_BASE = 4'd0;
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = 4'd8;
  localparam int                PAGE           = PAGE_BYTES_DEF;
  localparam int                CYCLE_LIMIT    = 300000;
  localparam int                ITEMS_PER_PHASE = 145;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind = '0;
  logic [63:0]       in_dma_address = '0;
  logic [31:0]       in_xfer_len = '0;
  logic [8:0]        in_entry_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [63:0]       out_prp_first;
  logic [63:0]       out_prp_second;
  logic [1:0]        out_status;
  logic [9:0]        out_list_entries;
  logic [63:0]       out_entry_value;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycles = 0;
  bit stall_results = 1'b0;
  bit steady;

  // no gaps on either side over a stretch of the random items
  assign steady = (items_sent >= 250) && (items_sent < 330);

  nvme_prp_descriptor_builder_top u_dut (.*);

  nvme_prp_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= stall_results ? 1'b0 : (steady || $urandom_range(99) >= 14);

  // long result stall while items keep coming, so the block backs up
  initial begin
    wait (items_sent >= 60);
    stall_results = 1'b1;
    repeat (80) @(posedge clk);
    stall_results = 1'b0;
  end

  function automatic in_item_t mk(logic [1:0] kind, logic [63:0] dma,
                                  logic [31:0] bytes, logic [8:0] idx);
    return '{kind: kind, dma_address: dma, xfer_len: bytes, entry_index: idx};
  endfunction

  function automatic in_item_t random_descriptor_item();
    in_item_t    it;
    int unsigned sel;
    int unsigned pages;
    it.dma_address = {$urandom, $urandom};
    if ($urandom_range(9) == 0)
      it.dma_address[63:20] = '1;
    sel = $urandom_range(99);
    if (sel < 50)      it.kind = KIND_BUILD;
    else if (sel < 75) it.kind = KIND_READ;
    else if (sel < 92) it.kind = KIND_RELEASE;
    else               it.kind = KIND_UNUSED;
    sel = $urandom_range(99);
    if (sel < 20) begin
      it.xfer_len = $urandom_range(PAGE);
    end else if (sel < 35) begin
      it.xfer_len = $urandom_range(2 * PAGE);
    end else if (sel < 85) begin
      // list sizes, a few right at and beyond capacity
      pages = ($urandom_range(9) == 0) ? $urandom_range(505, 520) : $urandom_range(2, 64);
      it.xfer_len = pages * PAGE + $urandom_range(PAGE - 1);
    end else begin
      it.xfer_len = $urandom;
    end
    it.entry_index = ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                               : 9'($urandom_range(70));
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_dma_address <= it.dma_address;
    in_xfer_len    <= it.xfer_len;
    in_entry_index <= it.entry_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(ADDR_LIST_BASE, {$urandom, $urandom});
    // unmapped register: must not disturb the list base
    write_reg(ADDR_UNMAPPED, {$urandom, $urandom});

    send_item(mk(KIND_BUILD, '0, '0, '0));
    send_item(mk(KIND_BUILD, '1, 32'd1, '0));
    // second page wraps past the top of the address space
    send_item(mk(KIND_BUILD, '1, 32'd2, '0));
    send_item(mk(KIND_BUILD, '0, 32'(PAGE), '0));
    send_item(mk(KIND_BUILD, 64'h123, 32'(2 * PAGE), '0));
    send_item(mk(KIND_READ, '0, '0, 9'd0));
    send_item(mk(KIND_READ, '0, '0, 9'd1));
    send_item(mk(KIND_READ, '0, '0, 9'd2));
    send_item(mk(KIND_READ, '1, '1, 9'd511));
    // list build while busy, then a small build that still succeeds
    send_item(mk(KIND_BUILD, '0, 32'd20000, '0));
    send_item(mk(KIND_BUILD, '0, 32'd100, '0));
    send_item(mk(KIND_RELEASE, '1, '1, '1));
    send_item(mk(KIND_READ, '0, '0, 9'd1));
    // full list, read its last entry
    send_item(mk(KIND_BUILD, '0, 32'(513 * PAGE), '0));
    send_item(mk(KIND_READ, '0, '0, 9'd511));
    send_item(mk(KIND_RELEASE, '0, '0, '0));
    // one entry over capacity clears the count
    send_item(mk(KIND_BUILD, '0, 32'(513 * PAGE + 1), '0));
    send_item(mk(KIND_READ, '0, '0, 9'd0));
    send_item(mk(KIND_BUILD, 64'hFFFF_FFFF_FFFF_F800, 32'h0001_0000, '0));
    send_item(mk(KIND_READ, '0, '0, 9'd0));
    send_item(mk(KIND_READ, '0, '0, 9'd15));
    send_item(mk(KIND_UNUSED, {$urandom, $urandom}, $urandom, 9'($urandom_range(511))));
    send_item(mk(KIND_RELEASE, '0, '0, '0));
    send_item(mk(KIND_BUILD, '1, '1, '0));
    drain();

    write_reg(ADDR_LIST_BASE, '1);
    repeat (ITEMS_PER_PHASE) send_item(random_descriptor_item());
    drain();

    write_reg(ADDR_LIST_BASE, '0);
    repeat (ITEMS_PER_PHASE) send_item(random_descriptor_item());
    drain();

    write_reg(ADDR_LIST_BASE, {$urandom, $urandom});
    repeat (ITEMS_PER_PHASE) send_item(random_descriptor_item());
    drain();

    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
